// ===== src/ogb_pkg.sv =====
// ----------------------------------------------------------------------------
// ogb_pkg
// Shared types and constants of the occupancy grid bitmap: command and status
// codes, microcode fields and the condition flags passed to the sequencer.
// ----------------------------------------------------------------------------
package ogb_pkg;

    localparam int MAP_WIDTH_DEF   = 40;
    localparam int MAP_LENGTH_DEF  = 40;
    localparam int STORE_WORDS_DEF = 64;

    localparam int WORD_W = 32;
    // signed linear cell index, holds -4096..65791 for 8-bit coordinates
    localparam int LIN_W  = 18;
    // signed cell coordinate, holds -15..255
    localparam int CRD_W  = 10;

    localparam logic [7:0] GAP_RESET = 8'd16;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_MARK   = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_BORDER = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_FREE     = 2'd0,
        ST_OCCUPIED = 2'd1,
        ST_OUTSIDE  = 2'd2,
        ST_DONE     = 2'd3
    } t_status;

    // datapath action of one control word
    typedef enum logic [3:0] {
        OP_NONE,
        OP_SWEEP,
        OP_FETCH,
        OP_BASE,
        OP_QCHK,
        OP_QBIT,
        OP_MRD,
        OP_MWR,
        OP_BINIT,
        OP_SET_TOP,
        OP_SET_BOT,
        OP_SET_LEFT,
        OP_SET_RIGHT,
        OP_STEP_W,
        OP_STEP_L,
        OP_DONE
    } t_op;

    typedef enum logic [3:0] {
        C_TRUE,
        C_SWEEP_LAST,
        C_IN_FIRE,
        C_Q_EXIT,
        C_CELL_LAST,
        C_BW_ZERO,
        C_GAP_SKIP,
        C_LOOP_DONE,
        C_OUT_FREE
    } t_cond;

    typedef enum logic [1:0] {
        SQ_BRANCH,
        SQ_CALL,
        SQ_RETURN,
        SQ_DISPATCH
    } t_seq;

    typedef enum logic [4:0] {
        S_INIT,
        S_FETCH,
        S_CLR,
        S_QBASE,
        S_QCHK,
        S_QBIT,
        S_MARK,
        S_MBASE,
        S_MRD,
        S_MWR,
        S_BINIT,
        S_BAGAP,
        S_BATOP,
        S_BABOT,
        S_BASTEP,
        S_BBLEFT,
        S_BBRIGHT,
        S_BBSTEP,
        S_DONE
    } t_step;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_seq  seq;
        t_step tgt;
        t_step alt;
        t_step ret;
    } t_uword;

    typedef struct packed {
        logic sweep_last;
        logic in_fire;
        logic q_exit;
        logic cell_last;
        logic bw_zero;
        logic gap_skip;
        logic loop_done;
        logic out_free;
    } t_flags;

endpackage

// ===== src/occupancy_grid_bitmap.sv =====
// ----------------------------------------------------------------------------
// occupancy_grid_bitmap
// One-bit-per-cell obstacle map in a word memory, run by a microcoded
// sequencer: clear, 3x3 mark, cell query and border frame.
// ----------------------------------------------------------------------------
// After reset the block sweeps the map to zero, one word per cycle, before it
// takes the first command. Commands are taken one at a time and each gives one
// status transaction. Every cell write is a read-modify-write on the word memory
// (read, then write). A query ends without reading its bit when the cell lies
// outside the map or beyond the store. Border issues
// 2*border_width*(MAP_WIDTH+MAP_LENGTH+2) marks, fewer on top rows whose x lies
// at or below the collection gap. A new command is taken while the previous
// status still waits on the master side.
module occupancy_grid_bitmap #(
    parameter int MAP_WIDTH   = ogb_pkg::MAP_WIDTH_DEF,
    parameter int MAP_LENGTH  = ogb_pkg::MAP_LENGTH_DEF,
    parameter int STORE_WORDS = ogb_pkg::STORE_WORDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,   // collection_gap
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,    // x_coord[7:0], y_coord[15:8], border_width[19:16]
    input  logic [1:0]  s_axis_tuser,    // command[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata     // cell_status[1:0]
);
    import ogb_pkg::*;

    localparam int AW = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_WORDS - 1);
    localparam logic signed [LIN_W-1:0] W_LIN      = LIN_W'(MAP_WIDTH);
    localparam logic signed [LIN_W-1:0] STORE_BITS = LIN_W'(STORE_WORDS * WORD_W);
    localparam logic signed [CRD_W-1:0] W_CRD = CRD_W'(MAP_WIDTH);
    localparam logic signed [CRD_W-1:0] L_CRD = CRD_W'(MAP_LENGTH);
    localparam logic [7:0] W_U8 = 8'(MAP_WIDTH);
    localparam logic [7:0] L_U8 = 8'(MAP_LENGTH);

    t_op    w_op;
    t_flags w_flags;
    t_cmd   w_cmd;

    logic [WORD_W-1:0] mem [STORE_WORDS];
    logic [WORD_W-1:0] r_rd_data;

    logic [7:0]              r_gap;
    logic [AW-1:0]           r_addr;
    logic                    r_out_valid;
    t_status                 r_out_status;
    t_status                 r_status;
    logic signed [CRD_W-1:0] r_cx;
    logic signed [CRD_W-1:0] r_cy;
    logic [3:0]              r_bw;
    logic [7:0]              r_i;
    logic [3:0]              r_j;
    logic [1:0]              r_dx;
    logic [1:0]              r_dy;
    logic signed [LIN_W-1:0] r_base;
    logic [AW-1:0]           r_waddr;
    logic [4:0]              r_wbit;
    logic                    r_lin_ok;
    logic [4:0]              r_qbit;

    logic                    in_fire;
    logic signed [LIN_W-1:0] off_y;
    logic signed [LIN_W-1:0] off_x;
    logic signed [LIN_W-1:0] lin;
    logic                    lin_ok;
    logic                    base_ok;
    logic                    q_outside;
    logic [AW-1:0]           rd_addr;
    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    logic [WORD_W-1:0]       mem_wdata;
    logic [7:0]              i_limit;
    logic                    j_last;
    logic                    i_at_limit;

    ogb_useq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .i_cmd   (w_cmd),
        .o_op    (w_op)
    );

    assign w_cmd         = t_cmd'(s_axis_tuser);
    assign s_axis_tready = (w_op == OP_FETCH);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out_status};

    // neighbor offset of the current cell of the 3x3 block
    always_comb begin
        case (r_dy)
            2'd0:    off_y = -W_LIN;
            2'd1:    off_y = '0;
            default: off_y = W_LIN;
        endcase
        case (r_dx)
            2'd0:    off_x = -LIN_W'(1);
            2'd1:    off_x = '0;
            default: off_x = LIN_W'(1);
        endcase
    end

    assign lin       = r_base + off_y + off_x;
    assign lin_ok    = !lin[LIN_W-1] && (lin < STORE_BITS);
    assign base_ok   = !r_base[LIN_W-1] && (r_base < STORE_BITS);
    assign q_outside = (r_cx > W_CRD) || (r_cy > L_CRD);
    assign rd_addr   = (w_op == OP_QCHK) ? r_base[AW+4:5] : lin[AW+4:5];

    assign i_limit    = (w_op == OP_STEP_L) ? L_U8 : W_U8;
    assign j_last     = (r_j == r_bw - 4'd1);
    assign i_at_limit = (r_i == i_limit);

    always_comb begin
        w_flags.sweep_last = (r_addr == LAST_ADDR);
        w_flags.in_fire    = in_fire;
        w_flags.q_exit     = q_outside || !base_ok;
        w_flags.cell_last  = (r_dx == 2'd2) && (r_dy == 2'd2);
        w_flags.bw_zero    = (r_bw == 4'd0);
        w_flags.gap_skip   = (r_i <= r_gap);
        w_flags.loop_done  = j_last && i_at_limit;
        w_flags.out_free   = !r_out_valid || m_axis_tready;
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_waddr;
        mem_wdata = r_rd_data | (WORD_W'(1) << r_wbit);
        case (w_op)
            OP_SWEEP: begin
                mem_we    = 1'b1;
                mem_waddr = r_addr;
                mem_wdata = '0;
            end
            OP_MWR: begin
                mem_we = r_lin_ok;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= mem[rd_addr];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap       <= GAP_RESET;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_gap <= i_cfg_wr_data;
            end
            if (w_op == OP_SWEEP) begin
                r_addr <= w_flags.sweep_last ? '0 : r_addr + AW'(1);
            end
            if (w_op == OP_DONE && w_flags.out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (w_op)
            OP_FETCH: begin
                if (in_fire) begin
                    r_cx     <= $signed(CRD_W'(s_axis_tdata[7:0]));
                    r_cy     <= $signed(CRD_W'(s_axis_tdata[15:8]));
                    r_bw     <= s_axis_tdata[19:16];
                    r_status <= ST_DONE;
                end
            end
            OP_BASE: begin
                r_base <= LIN_W'(r_cy) * W_LIN + LIN_W'(r_cx);
                r_dx   <= 2'd0;
                r_dy   <= 2'd0;
            end
            OP_QCHK: begin
                r_qbit <= r_base[4:0];
                if (q_outside) begin
                    r_status <= ST_OUTSIDE;
                end else if (!base_ok) begin
                    r_status <= ST_OCCUPIED;
                end
            end
            OP_QBIT: begin
                r_status <= r_rd_data[r_qbit] ? ST_OCCUPIED : ST_FREE;
            end
            OP_MRD: begin
                r_waddr  <= lin[AW+4:5];
                r_wbit   <= lin[4:0];
                r_lin_ok <= lin_ok;
            end
            OP_MWR: begin
                if (r_dx == 2'd2) begin
                    r_dx <= 2'd0;
                    r_dy <= r_dy + 2'd1;
                end else begin
                    r_dx <= r_dx + 2'd1;
                end
            end
            OP_BINIT: begin
                r_i <= '0;
                r_j <= '0;
            end
            OP_SET_TOP: begin
                r_cx <= $signed(CRD_W'(r_i));
                r_cy <= $signed(CRD_W'(r_j));
            end
            OP_SET_BOT: begin
                r_cx <= $signed(CRD_W'(r_i));
                r_cy <= L_CRD - $signed(CRD_W'(r_j));
            end
            OP_SET_LEFT: begin
                r_cx <= $signed(CRD_W'(r_j));
                r_cy <= $signed(CRD_W'(r_i));
            end
            OP_SET_RIGHT: begin
                r_cx <= W_CRD - $signed(CRD_W'(r_j));
                r_cy <= $signed(CRD_W'(r_i));
            end
            OP_STEP_W, OP_STEP_L: begin
                if (j_last) begin
                    r_j <= '0;
                    r_i <= i_at_limit ? 8'd0 : r_i + 8'd1;
                end else begin
                    r_j <= r_j + 4'd1;
                end
            end
            OP_DONE: begin
                if (w_flags.out_free) begin
                    r_out_status <= r_status;
                end
            end
            default: begin
            end
        endcase
    end

    // a taken command always leaves the fetch step
    a_fetch_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (w_op != OP_FETCH))
        else $error("sequencer stayed in fetch after a command transaction");

    // every clearing sweep finishes with the address back at zero
    a_sweep_rewound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_op == OP_FETCH) |-> (r_addr == '0))
        else $error("clear sweep address not rewound");

    // a cell write always follows its read
    a_rmw_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_op == OP_MWR) |-> ($past(w_op) == OP_MRD))
        else $error("cell write without preceding read");

    a_query_outside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_op == OP_QCHK && q_outside) |=> (r_status == ST_OUTSIDE))
        else $error("out of bounds query not reported as outside");

endmodule

// ===== src/ogb_useq.sv =====
// ----------------------------------------------------------------------------
// ogb_useq
// Microcode sequencer: step counter, one-level return register and the
// control store that drives the occupancy grid datapath.
// ----------------------------------------------------------------------------
module ogb_useq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ogb_pkg::t_flags i_flags,
    input  ogb_pkg::t_cmd   i_cmd,
    output ogb_pkg::t_op    o_op
);
    import ogb_pkg::*;

    function automatic t_uword uw(input t_op op, input t_cond cond, input t_seq seq,
                                  input t_step tgt, input t_step alt, input t_step ret);
        t_uword w;
        w.op   = op;
        w.cond = cond;
        w.seq  = seq;
        w.tgt  = tgt;
        w.alt  = alt;
        w.ret  = ret;
        return w;
    endfunction

    // control store
    function automatic t_uword ucode(input t_step s);
        t_uword w;
        unique case (s)
            S_INIT:    w = uw(OP_SWEEP, C_SWEEP_LAST, SQ_BRANCH, S_FETCH, S_INIT, S_DONE);
            S_FETCH:   w = uw(OP_FETCH, C_IN_FIRE, SQ_DISPATCH, S_FETCH, S_FETCH, S_DONE);
            S_CLR:     w = uw(OP_SWEEP, C_SWEEP_LAST, SQ_BRANCH, S_DONE, S_CLR, S_DONE);
            S_QBASE:   w = uw(OP_BASE, C_TRUE, SQ_BRANCH, S_QCHK, S_QCHK, S_DONE);
            S_QCHK:    w = uw(OP_QCHK, C_Q_EXIT, SQ_BRANCH, S_DONE, S_QBIT, S_DONE);
            S_QBIT:    w = uw(OP_QBIT, C_TRUE, SQ_BRANCH, S_DONE, S_DONE, S_DONE);
            S_MARK:    w = uw(OP_NONE, C_TRUE, SQ_CALL, S_MBASE, S_MBASE, S_DONE);
            S_MBASE:   w = uw(OP_BASE, C_TRUE, SQ_BRANCH, S_MRD, S_MRD, S_DONE);
            S_MRD:     w = uw(OP_MRD, C_TRUE, SQ_BRANCH, S_MWR, S_MWR, S_DONE);
            S_MWR:     w = uw(OP_MWR, C_CELL_LAST, SQ_RETURN, S_DONE, S_MRD, S_DONE);
            S_BINIT:   w = uw(OP_BINIT, C_BW_ZERO, SQ_BRANCH, S_DONE, S_BAGAP, S_DONE);
            S_BAGAP:   w = uw(OP_NONE, C_GAP_SKIP, SQ_BRANCH, S_BABOT, S_BATOP, S_DONE);
            S_BATOP:   w = uw(OP_SET_TOP, C_TRUE, SQ_CALL, S_MBASE, S_MBASE, S_BABOT);
            S_BABOT:   w = uw(OP_SET_BOT, C_TRUE, SQ_CALL, S_MBASE, S_MBASE, S_BASTEP);
            S_BASTEP:  w = uw(OP_STEP_W, C_LOOP_DONE, SQ_BRANCH, S_BBLEFT, S_BAGAP, S_DONE);
            S_BBLEFT:  w = uw(OP_SET_LEFT, C_TRUE, SQ_CALL, S_MBASE, S_MBASE, S_BBRIGHT);
            S_BBRIGHT: w = uw(OP_SET_RIGHT, C_TRUE, SQ_CALL, S_MBASE, S_MBASE, S_BBSTEP);
            S_BBSTEP:  w = uw(OP_STEP_L, C_LOOP_DONE, SQ_BRANCH, S_DONE, S_BBLEFT, S_DONE);
            S_DONE:    w = uw(OP_DONE, C_OUT_FREE, SQ_BRANCH, S_FETCH, S_DONE, S_DONE);
            default:   w = uw(OP_NONE, C_TRUE, SQ_BRANCH, S_INIT, S_INIT, S_DONE);
        endcase
        return w;
    endfunction

    t_step  r_pc;
    t_step  n_pc;
    t_step  r_ret;
    t_step  n_ret;
    t_uword w_uw;
    logic   w_cond_ok;
    t_step  w_disp;

    assign w_uw = ucode(r_pc);
    assign o_op = w_uw.op;

    always_comb begin
        case (w_uw.cond)
            C_SWEEP_LAST: w_cond_ok = i_flags.sweep_last;
            C_IN_FIRE:    w_cond_ok = i_flags.in_fire;
            C_Q_EXIT:     w_cond_ok = i_flags.q_exit;
            C_CELL_LAST:  w_cond_ok = i_flags.cell_last;
            C_BW_ZERO:    w_cond_ok = i_flags.bw_zero;
            C_GAP_SKIP:   w_cond_ok = i_flags.gap_skip;
            C_LOOP_DONE:  w_cond_ok = i_flags.loop_done;
            C_OUT_FREE:   w_cond_ok = i_flags.out_free;
            default:      w_cond_ok = 1'b1;
        endcase
    end

    always_comb begin
        unique case (i_cmd)
            CMD_CLEAR:  w_disp = S_CLR;
            CMD_MARK:   w_disp = S_MARK;
            CMD_QUERY:  w_disp = S_QBASE;
            CMD_BORDER: w_disp = S_BINIT;
            default:    w_disp = S_FETCH;
        endcase
    end

    always_comb begin
        n_ret = r_ret;
        unique case (w_uw.seq)
            SQ_BRANCH:   n_pc = w_cond_ok ? w_uw.tgt : w_uw.alt;
            SQ_CALL: begin
                n_pc  = w_uw.tgt;
                n_ret = w_uw.ret;
            end
            SQ_RETURN:   n_pc = w_cond_ok ? r_ret : w_uw.alt;
            SQ_DISPATCH: n_pc = w_cond_ok ? w_disp : w_uw.alt;
            default:     n_pc = S_INIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc  <= S_INIT;
            r_ret <= S_DONE;
        end else begin
            r_pc  <= n_pc;
            r_ret <= n_ret;
        end
    end

endmodule
